### rtl/ccbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbb_pkg
// shared widths, register indexes and reset values for the circumcircle box
// ----------------------------------------------------------------------------
package ccbb_pkg;

	localparam int CoordW   = 16;
	localparam int BoxW     = 32;
	localparam int MarginW  = 12;
	localparam int RegIdxW  = 2;
	localparam int CfgDataW = 16;

	localparam logic [RegIdxW-1:0] REG_COLLINEAR  = 2'd0;
	localparam logic [RegIdxW-1:0] REG_MIN_RADIUS = 2'd1;
	localparam logic [RegIdxW-1:0] REG_MARGIN     = 2'd2;

	localparam logic [15:0] RST_COLLINEAR  = 16'd128;
	localparam logic [15:0] RST_MIN_RADIUS = 16'd8;
	localparam logic [11:0] RST_MARGIN     = 12'd128;

	// configuration snapshot seen by the datapath
	typedef struct packed {
		logic [15:0] collinear_threshold;
		logic [15:0] min_radius;
		logic [11:0] margin;
	} cfg_t;

endpackage

### rtl/circumcircle_bounding_box_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcircle_bounding_box_top
// bounding box of the circle through three Q12.4 points, widened by a margin
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        sink       in_valid/in_stall  first/middle/last x,y
// out       source     out_valid/out_stall box_left/top/right/bottom, used_circle
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// one triple enters per cycle unless the output stalls; the pipeline is five
// front stages, the bit-per-stage divider (60 stages), three stages around the
// square, the square root (34 stages) and the output register
// reset clears all valid bits and loads the register reset values
// a stall at the output freezes the whole pipeline, nothing lost or repeated
// ----------------------------------------------------------------------------
module circumcircle_bounding_box_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [15:0]          first_x,
	input  logic signed [15:0]          first_y,
	input  logic signed [15:0]          middle_x,
	input  logic signed [15:0]          middle_y,
	input  logic signed [15:0]          last_x,
	input  logic signed [15:0]          last_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          box_left,
	output logic signed [31:0]          box_top,
	output logic signed [31:0]          box_right,
	output logic signed [31:0]          box_bottom,
	output logic                        used_circle,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ccbb_pkg::RegIdxW-1:0] cfg_index,
	input  logic [ccbb_pkg::CfgDataW-1:0] cfg_data
);
	import ccbb_pkg::*;

	// whole pipeline advances unless a held result is stalled
	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.collinear_threshold <= RST_COLLINEAR;
			cfg_q.min_radius          <= RST_MIN_RADIUS;
			cfg_q.margin              <= RST_MARGIN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLLINEAR:  cfg_q.collinear_threshold <= cfg_data;
				REG_MIN_RADIUS: cfg_q.min_radius          <= cfg_data;
				REG_MARGIN:     cfg_q.margin              <= cfg_data[MarginW-1:0];
				default: ;
			endcase
		end
	end

	// ---- stage 1: differences and sums
	logic               v_s1;
	logic signed [17:0] mbcx_s1, mbcy_s1, mabx_s1, maby_s1;
	logic signed [17:0] sbcx_s1, sbcy_s1, sabx_s1, saby_s1;
	logic signed [15:0] ax_s1, ay_s1;
	logic signed [15:0] pminx_s1, pminy_s1, pmaxx_s1, pmaxy_s1;

	function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction
	function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mbcx_s1  <= 18'(middle_x) - 18'(last_x);
			mbcy_s1  <= 18'(middle_y) - 18'(last_y);
			mabx_s1  <= 18'(first_x) - 18'(middle_x);
			maby_s1  <= 18'(first_y) - 18'(middle_y);
			sbcx_s1  <= 18'(middle_x) + 18'(last_x);
			sbcy_s1  <= 18'(middle_y) + 18'(last_y);
			sabx_s1  <= 18'(first_x) + 18'(middle_x);
			saby_s1  <= 18'(first_y) + 18'(middle_y);
			ax_s1    <= first_x;
			ay_s1    <= first_y;
			pminx_s1 <= min3(first_x, middle_x, last_x);
			pminy_s1 <= min3(first_y, middle_y, last_y);
			pmaxx_s1 <= max3(first_x, middle_x, last_x);
			pmaxy_s1 <= max3(first_y, middle_y, last_y);
		end
	end

	// ---- stage 2: products (18x18)
	// m00=-2mbcx m01=-2mbcy m10=-2mabx m11=-2maby
	// det = 4*(mbcx*maby - mbcy*mabx)
	logic               v_s2;
	logic signed [35:0] p_bx_ay_s2, p_by_ax_s2;
	logic signed [35:0] p0a_s2, p0b_s2, p1a_s2, p1b_s2;
	logic signed [17:0] mbcx_s2, mbcy_s2, mabx_s2, maby_s2;
	logic signed [15:0] ax_s2, ay_s2;
	logic signed [15:0] pminx_s2, pminy_s2, pmaxx_s2, pmaxy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_bx_ay_s2 <= mbcx_s1 * maby_s1;
			p_by_ax_s2 <= mbcy_s1 * mabx_s1;
			p0a_s2     <= sbcx_s1 * mbcx_s1;
			p0b_s2     <= sbcy_s1 * mbcy_s1;
			p1a_s2     <= sabx_s1 * mabx_s1;
			p1b_s2     <= saby_s1 * maby_s1;
			mbcx_s2 <= mbcx_s1; mbcy_s2 <= mbcy_s1;
			mabx_s2 <= mabx_s1; maby_s2 <= maby_s1;
			ax_s2 <= ax_s1; ay_s2 <= ay_s1;
			pminx_s2 <= pminx_s1; pminy_s2 <= pminy_s1;
			pmaxx_s2 <= pmaxx_s1; pmaxy_s2 <= pmaxy_s1;
		end
	end

	// ---- stage 3: det, b0, b1
	logic               v_s3;
	logic signed [39:0] det_s3;
	logic signed [37:0] b0_s3, b1_s3;
	logic signed [17:0] mbcx_s3, mbcy_s3, mabx_s3, maby_s3;
	logic signed [15:0] ax_s3, ay_s3;
	logic signed [15:0] pminx_s3, pminy_s3, pmaxx_s3, pmaxy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= (40'(p_bx_ay_s2) - 40'(p_by_ax_s2)) <<< 2;
			b0_s3  <= -(38'(p0a_s2) + 38'(p0b_s2));
			b1_s3  <= -(38'(p1a_s2) + 38'(p1b_s2));
			mbcx_s3 <= mbcx_s2; mbcy_s3 <= mbcy_s2;
			mabx_s3 <= mabx_s2; maby_s3 <= maby_s2;
			ax_s3 <= ax_s2; ay_s3 <= ay_s2;
			pminx_s3 <= pminx_s2; pminy_s3 <= pminy_s2;
			pmaxx_s3 <= pmaxx_s2; pmaxy_s3 <= pmaxy_s2;
		end
	end

	// ---- stage 4: numerator products, 38x18
	// numx = b0*m11 - b1*m01 = -2*(b0*maby - b1*mbcy)
	// numy = b1*m00 - b0*m10 = -2*(b1*mbcx - b0*mabx)
	logic               v_s4;
	logic signed [55:0] nxa_s4, nxb_s4, nya_s4, nyb_s4;
	logic signed [39:0] det_s4;
	logic signed [15:0] ax_s4, ay_s4;
	logic signed [15:0] pminx_s4, pminy_s4, pmaxx_s4, pmaxy_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nxa_s4 <= b0_s3 * maby_s3;
			nxb_s4 <= b1_s3 * mbcy_s3;
			nya_s4 <= b1_s3 * mbcx_s3;
			nyb_s4 <= b0_s3 * mabx_s3;
			det_s4 <= det_s3;
			ax_s4 <= ax_s3; ay_s4 <= ay_s3;
			pminx_s4 <= pminx_s3; pminy_s4 <= pminy_s3;
			pmaxx_s4 <= pmaxx_s3; pmaxy_s4 <= pmaxy_s3;
		end
	end

	// ---- stage 5: signs and magnitudes for the dividers
	localparam int NumW = 60;
	localparam int DenW = 40;
	logic               v_s5;
	logic [NumW-1:0]    nxm_s5, nym_s5;
	logic [DenW-1:0]    detm_s5;
	logic               negx_s5, negy_s5, det_ok_s5;
	logic signed [15:0] ax_s5, ay_s5;
	logic signed [15:0] pminx_s5, pminy_s5, pmaxx_s5, pmaxy_s5;
	logic signed [NumW-1:0] nx_c, ny_c;
	logic [DenW-1:0]        detm_c;
	always_comb begin
		nx_c   = -((NumW'(nxa_s4) - NumW'(nxb_s4)) <<< 1);
		ny_c   = -((NumW'(nya_s4) - NumW'(nyb_s4)) <<< 1);
		detm_c = det_s4[DenW-1] ? DenW'(-det_s4) : DenW'(det_s4);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nxm_s5    <= nx_c[NumW-1] ? NumW'(-nx_c) : NumW'(nx_c);
			nym_s5    <= ny_c[NumW-1] ? NumW'(-ny_c) : NumW'(ny_c);
			negx_s5   <= nx_c[NumW-1] ^ det_s4[DenW-1];
			negy_s5   <= ny_c[NumW-1] ^ det_s4[DenW-1];
			detm_s5   <= detm_c;
			det_ok_s5 <= (detm_c != '0) &&
				(detm_c >= DenW'(cfg_q.collinear_threshold));
			ax_s5 <= ax_s4; ay_s5 <= ay_s4;
			pminx_s5 <= pminx_s4; pminy_s5 <= pminy_s4;
			pmaxx_s5 <= pmaxx_s4; pmaxy_s5 <= pmaxy_s4;
		end
	end

	// ---- dividers: x side data rides on the x divider, y side data on the y one
	localparam int TagXW = 2 + 16 * 3;
	localparam int TagYW = 1 + 16 * 3;
	logic [TagXW-1:0] tagx_in, tagx_out;
	logic [TagYW-1:0] tagy_in, tagy_out;
	logic             vdx, vdy;
	logic [NumW-1:0]  qx, qy;
	assign tagx_in = {negx_s5, det_ok_s5, ax_s5, pminx_s5, pmaxx_s5};
	assign tagy_in = {negy_s5, ay_s5, pminy_s5, pmaxy_s5};

	ccbb_div #(.NumW(NumW), .DenW(DenW), .TagW(TagXW)) u_divx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(nxm_s5), .den(detm_s5), .tag_in(tagx_in),
		.out_valid(vdx), .quo(qx), .tag_out(tagx_out)
	);
	ccbb_div #(.NumW(NumW), .DenW(DenW), .TagW(TagYW)) u_divy (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(nym_s5), .den(detm_s5), .tag_in(tagy_in),
		.out_valid(vdy), .quo(qy), .tag_out(tagy_out)
	);

	logic negx_d, negy_d, det_ok_d;
	logic signed [15:0] ax_d, ay_d, pminx_d, pminy_d, pmaxx_d, pmaxy_d;
	assign {negx_d, det_ok_d, ax_d, pminx_d, pmaxx_d} = tagx_out;
	assign {negy_d, ay_d, pminy_d, pmaxy_d}           = tagy_out;

	// ---- stage 6: signed center, range check, distance terms
	logic               v_s6;
	logic signed [31:0] cx_s6, cy_s6;
	logic               ok_s6;
	logic [32:0]        ux_s6, uy_s6;
	logic signed [15:0] pminx_s6, pminy_s6, pmaxx_s6, pmaxy_s6;
	logic signed [NumW:0] cxw, cyw;
	logic signed [33:0]   dxw, dyw;
	logic                 cfit;
	always_comb begin
		cxw  = negx_d ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		cyw  = negy_d ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		cfit = (cxw >= -(61'sd1 <<< 31)) && (cxw < (61'sd1 <<< 31)) &&
			(cyw >= -(61'sd1 <<< 31)) && (cyw < (61'sd1 <<< 31));
		dxw  = 34'(ax_d) - 34'($signed(cxw[31:0]));
		dyw  = 34'(ay_d) - 34'($signed(cyw[31:0]));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= vdx && vdy;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s6 <= cxw[31:0];
			cy_s6 <= cyw[31:0];
			ok_s6 <= det_ok_d && cfit;
			ux_s6 <= dxw[33] ? 33'(-dxw) : 33'(dxw);
			uy_s6 <= dyw[33] ? 33'(-dyw) : 33'(dyw);
			pminx_s6 <= pminx_d; pminy_s6 <= pminy_d;
			pmaxx_s6 <= pmaxx_d; pmaxy_s6 <= pmaxy_d;
		end
	end

	// ---- stage 7: squares of the distance terms
	logic               v_s7;
	logic [65:0]        sqx_s7, sqy_s7;
	logic signed [31:0] cx_s7, cy_s7;
	logic               ok_s7;
	logic signed [15:0] pminx_s7, pminy_s7, pmaxx_s7, pmaxy_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s7 <= ux_s6 * ux_s6;
			sqy_s7 <= uy_s6 * uy_s6;
			cx_s7 <= cx_s6; cy_s7 <= cy_s6; ok_s7 <= ok_s6;
			pminx_s7 <= pminx_s6; pminy_s7 <= pminy_s6;
			pmaxx_s7 <= pmaxx_s6; pmaxy_s7 <= pmaxy_s6;
		end
	end

	// ---- stage 8: radius squared
	localparam int TagRW = 1 + 32 * 2 + 16 * 4;
	logic               v_s8;
	logic [67:0]        rsq_s8;
	logic [TagRW-1:0]   tag_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rsq_s8 <= 68'(sqx_s7) + 68'(sqy_s7);
			tag_s8 <= {ok_s7, cx_s7, cy_s7, pminx_s7, pminy_s7,
				pmaxx_s7, pmaxy_s7};
		end
	end

	// ---- square root
	logic             vr;
	logic [33:0]      root;
	logic [TagRW-1:0] tag_r;
	ccbb_sqrt #(.RadW(68), .TagW(TagRW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s8),
		.rad(rsq_s8), .tag_in(tag_s8),
		.out_valid(vr), .root(root), .tag_out(tag_r)
	);

	logic               ok_r;
	logic signed [31:0] cx_r, cy_r;
	logic signed [15:0] pminx_r, pminy_r, pmaxx_r, pmaxy_r;
	assign {ok_r, cx_r, cy_r, pminx_r, pminy_r, pmaxx_r, pmaxy_r} = tag_r;

	// ---- output stage: edges, checks, selection
	logic signed [36:0] rm, e0, e1, e2, e3;
	logic signed [31:0] mg;
	logic               circ;
	always_comb begin
		mg   = 32'(cfg_q.margin);
		rm   = 37'(root) + 37'(mg);
		e0   = 37'(cx_r) - rm;
		e1   = 37'(cy_r) - rm;
		e2   = 37'(cx_r) + rm;
		e3   = 37'(cy_r) + rm;
		circ = ok_r && (root >= 34'(cfg_q.min_radius)) &&
			(e0 >= -(37'sd1 <<< 31)) && (e1 >= -(37'sd1 <<< 31)) &&
			(e2 < (37'sd1 <<< 31)) && (e3 < (37'sd1 <<< 31));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vr;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			used_circle <= circ;
			box_left    <= circ ? e0[31:0] : 32'(pminx_r) - mg;
			box_top     <= circ ? e1[31:0] : 32'(pminy_r) - mg;
			box_right   <= circ ? e2[31:0] : 32'(pmaxx_r) + mg;
			box_bottom  <= circ ? e3[31:0] : 32'(pmaxy_r) + mg;
		end
	end
endmodule

### rtl/ccbb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbb_div
// pipelined restoring divider, one quotient bit per stage, truncating quotient
// ----------------------------------------------------------------------------
module ccbb_div #(
	parameter int NumW = 72,
	parameter int DenW = 36,
	parameter int TagW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [NumW-1:0]        num,
	input  logic [DenW-1:0]        den,
	input  logic [TagW-1:0]        tag_in,
	output logic                   out_valid,
	output logic [NumW-1:0]        quo,
	output logic [TagW-1:0]        tag_out
);
	// unsigned magnitudes in, unsigned quotient out
	logic [NumW-1:0] rem_s [NumW+1];
	logic [NumW-1:0] q_s   [NumW+1];
	logic [DenW-1:0] d_s   [NumW+1];
	logic [TagW-1:0] t_s   [NumW+1];
	logic            v_s   [NumW+1];

	always_comb begin
		rem_s[0] = '0;
		q_s[0]   = num;
		d_s[0]   = den;
		t_s[0]   = tag_in;
		v_s[0]   = in_valid;
	end

	genvar g;
	generate
		for (g = 0; g < NumW; g++) begin : g_stage
			logic [NumW:0]   trial;
			logic [NumW-1:0] rem_n;
			logic [NumW-1:0] q_n;
			always_comb begin
				trial = {rem_s[g], q_s[g][NumW-1]};
				if (trial >= {{(NumW+1-DenW){1'b0}}, d_s[g]}) begin
					rem_n = NumW'(trial - {{(NumW+1-DenW){1'b0}}, d_s[g]});
					q_n   = {q_s[g][NumW-2:0], 1'b1};
				end else begin
					rem_n = trial[NumW-1:0];
					q_n   = {q_s[g][NumW-2:0], 1'b0};
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[g+1] <= 1'b0;
				end else if (en) begin
					v_s[g+1] <= v_s[g];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= rem_n;
					q_s[g+1]   <= q_n;
					d_s[g+1]   <= d_s[g];
					t_s[g+1]   <= t_s[g];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[NumW];
	assign quo       = q_s[NumW];
	assign tag_out   = t_s[NumW];
endmodule

### rtl/ccbb_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbb_sqrt
// pipelined integer square root, one result bit per stage, rounds down
// ----------------------------------------------------------------------------
module ccbb_sqrt #(
	parameter int RadW = 66,
	parameter int TagW = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [RadW-1:0]         rad,
	input  logic [TagW-1:0]         tag_in,
	output logic                    out_valid,
	output logic [RadW/2-1:0]       root,
	output logic [TagW-1:0]         tag_out
);
	localparam int Steps = RadW / 2;
	localparam int RemW  = Steps + 2;

	logic [RadW-1:0]  x_s [Steps+1];
	logic [RemW-1:0]  r_s [Steps+1];
	logic [Steps-1:0] q_s [Steps+1];
	logic [TagW-1:0]  t_s [Steps+1];
	logic             v_s [Steps+1];

	always_comb begin
		x_s[0] = rad;
		r_s[0] = '0;
		q_s[0] = '0;
		t_s[0] = tag_in;
		v_s[0] = in_valid;
	end

	genvar g;
	generate
		for (g = 0; g < Steps; g++) begin : g_stage
			logic [RemW-1:0] rem_sh;
			logic [RemW-1:0] trial;
			logic [RemW-1:0] rem_n;
			logic [Steps-1:0] q_n;
			always_comb begin
				rem_sh = {r_s[g][RemW-3:0], x_s[g][RadW-1:RadW-2]};
				trial  = {q_s[g], 2'b01};
				if (rem_sh >= trial) begin
					rem_n = rem_sh - trial;
					q_n   = {q_s[g][Steps-2:0], 1'b1};
				end else begin
					rem_n = rem_sh;
					q_n   = {q_s[g][Steps-2:0], 1'b0};
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[g+1] <= 1'b0;
				end else if (en) begin
					v_s[g+1] <= v_s[g];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[g+1] <= {x_s[g][RadW-3:0], 2'b00};
					r_s[g+1] <= rem_n;
					q_s[g+1] <= q_n;
					t_s[g+1] <= t_s[g];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[Steps];
	assign root      = q_s[Steps];
	assign tag_out   = t_s[Steps];
endmodule

### dv/tb_circumcircle_bounding_box_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circumcircle_bounding_box_top
// Drives random and corner-case point triples into the circumcircle box
// block. Each accepted triple goes to a software model of the block, and
// each box that comes out is checked field by field against the oldest
// predicted box. Idle gaps and stalls are random on both sides, and the
// three registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

class box_scoreboard;
	typedef struct {
		logic signed [31:0] left, top, right, bottom;
		logic               circle;
	} box_t;

	box_t        pending[$];
	int          errors;
	logic [15:0] thr, min_r;
	logic [11:0] mg;

	function void reset_regs();
		thr   = ccbb_pkg::RST_COLLINEAR;
		min_r = ccbb_pkg::RST_MIN_RADIUS;
		mg    = ccbb_pkg::RST_MARGIN;
	endfunction

	function void write_reg(logic [1:0] idx, logic [15:0] val);
		case (idx)
			ccbb_pkg::REG_COLLINEAR: begin
				thr = val;
			end
			ccbb_pkg::REG_MIN_RADIUS: begin
				min_r = val;
			end
			ccbb_pkg::REG_MARGIN: begin
				mg = val[11:0];
			end
			default: begin
			end
		endcase
	endfunction

	static function longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	static function bit fits32(longint v);
		return v >= -64'sd2147483648 && v <= 64'sd2147483647;
	endfunction

	function void note_triple(logic signed [15:0] ax, ay, bx, by, qx, qy);
		longint a_x, a_y, b_x, b_y, c_x, c_y, m;
		longint m00, m01, m10, m11, det, b0, b1, cx, cy, dx, dy, r;
		longint e0, e1, e2, e3, adet;
		bit circ;
		box_t bx_out;
		a_x = ax; a_y = ay; b_x = bx; b_y = by; c_x = qx; c_y = qy;
		m = mg;
		circ = 0;
		m00 = -2 * (b_x - c_x); m01 = -2 * (b_y - c_y);
		m10 = -2 * (a_x - b_x); m11 = -2 * (a_y - b_y);
		det = m00 * m11 - m01 * m10;
		adet = det < 0 ? -det : det;
		if (det != 0 && adet >= longint'(thr)) begin
			b0 = -((b_x + c_x) * (b_x - c_x) + (b_y + c_y) * (b_y - c_y));
			b1 = -((a_x + b_x) * (a_x - b_x) + (a_y + b_y) * (a_y - b_y));
			cx = (b0 * m11 - b1 * m01) / det;
			cy = (b1 * m00 - b0 * m10) / det;
			if (fits32(cx) && fits32(cy)) begin
				dx = a_x - cx; dy = a_y - cy;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				r = longint'(floor_sqrt(longint'(dx) * dx + longint'(dy) * dy));
				if (r >= longint'(min_r)) begin
					e0 = cx - r - m; e1 = cy - r - m;
					e2 = cx + r + m; e3 = cy + r + m;
					circ = fits32(e0) && fits32(e1) && fits32(e2) && fits32(e3);
				end
			end
		end
		if (!circ) begin
			e0 = (a_x < b_x ? (a_x < c_x ? a_x : c_x) : (b_x < c_x ? b_x : c_x)) - m;
			e1 = (a_y < b_y ? (a_y < c_y ? a_y : c_y) : (b_y < c_y ? b_y : c_y)) - m;
			e2 = (a_x > b_x ? (a_x > c_x ? a_x : c_x) : (b_x > c_x ? b_x : c_x)) + m;
			e3 = (a_y > b_y ? (a_y > c_y ? a_y : c_y) : (b_y > c_y ? b_y : c_y)) + m;
		end
		bx_out.left = e0[31:0]; bx_out.top = e1[31:0];
		bx_out.right = e2[31:0]; bx_out.bottom = e3[31:0];
		bx_out.circle = circ;
		pending.push_back(bx_out);
	endfunction

	function void check_box(logic signed [31:0] l, t, r, b, logic c);
		box_t e;
		if (pending.size() == 0) begin
			$error("box with no triple waiting: %0d %0d %0d %0d %0d", l, t, r, b, c);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (l !== e.left) begin
			$error("box_left expected %0d actual %0d", e.left, l); errors++;
		end
		if (t !== e.top) begin
			$error("box_top expected %0d actual %0d", e.top, t); errors++;
		end
		if (r !== e.right) begin
			$error("box_right expected %0d actual %0d", e.right, r); errors++;
		end
		if (b !== e.bottom) begin
			$error("box_bottom expected %0d actual %0d", e.bottom, b); errors++;
		end
		if (c !== e.circle) begin
			$error("used_circle expected %0d actual %0d", e.circle, c); errors++;
		end
	endfunction
endclass

module tb_circumcircle_bounding_box_top;
	import ccbb_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, used_circle;
	logic signed [15:0] first_x, first_y, middle_x, middle_y, last_x, last_y;
	logic signed [31:0] box_left, box_top, box_right, box_bottom;
	logic cfg_valid, cfg_ready;
	logic [RegIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	box_scoreboard sb;

	circumcircle_bounding_box_top dut (.*);

	// 2 ns clock
	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// idle length: none half of the time, else mostly short, sometimes long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receive side: random stalls, every transfer checked
	initial begin
		int g;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_box(box_left, box_top, box_right, box_bottom, used_circle);
			if (out_stall) begin
				if (g > 0) g--;
				if (g == 0) out_stall <= 1'b0;
			end else if ($urandom_range(0, 9) < 2) begin
				g = pick_gap();
				if (g > 0) out_stall <= 1'b1;
			end
		end
	end

	// one triple transfer, with an optional idle gap before it
	task automatic send_triple(logic signed [15:0] ax, ay, bx, by, qx, qy);
		int g;
		g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_x <= ax; first_y <= ay; middle_x <= bx;
		middle_y <= by; last_x <= qx; last_y <= qy;
		do @(posedge clk); while (in_stall);
		sb.note_triple(ax, ay, bx, by, qx, qy);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [RegIdxW-1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random coordinate: full range, within +-span, or one of the extremes
	function automatic logic signed [15:0] coord(int span);
		int p;
		p = $urandom_range(0, 19);
		if (p == 0) return 16'sh7fff;
		if (p == 1) return 16'sh8000;
		if (p < 6) return 16'($urandom);
		return 16'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// triples on a real circle with random center and radius
	task automatic send_on_circle(int span);
		int cxv, cyv, rad;
		real a0, a1, a2;
		cxv = $signed($urandom_range(0, 2 * span)) - span;
		cyv = $signed($urandom_range(0, 2 * span)) - span;
		rad = $urandom_range(1, span);
		a0 = $urandom_range(0, 6283) / 1000.0;
		a1 = $urandom_range(0, 6283) / 1000.0;
		a2 = $urandom_range(0, 6283) / 1000.0;
		send_triple(16'(cxv + $rtoi(rad * $cos(a0))), 16'(cyv + $rtoi(rad * $sin(a0))),
			16'(cxv + $rtoi(rad * $cos(a1))), 16'(cyv + $rtoi(rad * $sin(a1))),
			16'(cxv + $rtoi(rad * $cos(a2))), 16'(cyv + $rtoi(rad * $sin(a2))));
	endtask

	task automatic random_phase(int n, int span);
		int k, s;
		for (k = 0; k < n; k++) begin
			s = $urandom_range(0, 9);
			if (s < 5) send_on_circle(span);
			else if (s < 7) begin
				// nearly collinear: third point close to the line of the first two
				logic signed [15:0] ax, ay, bx, by;
				ax = coord(span); ay = coord(span); bx = coord(span); by = coord(span);
				send_triple(ax, ay, bx, by, 16'(2 * bx - ax + $urandom_range(0, 2) - 1),
					16'(2 * by - ay + $urandom_range(0, 2) - 1));
			end else
				send_triple(coord(span), coord(span), coord(span),
					coord(span), coord(span), coord(span));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		arst_n = 1'b0;
		in_valid = 1'b0;
		first_x = '0; first_y = '0; middle_x = '0;
		middle_y = '0; last_x = '0; last_y = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, collinear, tiny and huge circles, overflows
		send_triple(0, 0, 0, 0, 0, 0);
		send_triple(0, 0, 160, 0, 0, 160);
		send_triple(0, 0, 16, 0, 32, 0);
		send_triple(0, 0, 1, 0, 0, 1);
		send_triple(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		send_triple(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_triple(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7fff);
		send_triple(16'sh8000, 0, 16'sh7fff, 1, 0, 16'sh8000);
		send_triple(16'sh8000, 16'sh8000, 0, 0, 16'sh7fff, 16'sh7fff);
		send_triple(-100, 50, 300, 50, 100, 250);
		send_triple(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_triple(-1, -1, 16'sh7fff, 16'sh7ffe, 16'sh8000, 16'sh8001);
		go_idle();

		// extreme register settings, each followed by random traffic
		write_reg(REG_COLLINEAR, 16'hffff);
		write_reg(REG_MIN_RADIUS, 16'hffff);
		write_reg(REG_MARGIN, 16'h0fff);
		random_phase(150, 32767);
		go_idle();

		write_reg(REG_COLLINEAR, 16'd0);
		write_reg(REG_MIN_RADIUS, 16'd0);
		write_reg(REG_MARGIN, 16'd0);
		send_triple(0, 0, 1, 0, 0, 1);
		send_triple(0, 0, 16, 0, 32, 0);
		random_phase(200, 200);
		go_idle();

		write_reg(REG_COLLINEAR, 16'($urandom));
		write_reg(REG_MIN_RADIUS, 16'($urandom_range(0, 4000)));
		write_reg(REG_MARGIN, 16'($urandom_range(0, 4095)));
		random_phase(250, 32767);
		go_idle();

		write_reg(REG_COLLINEAR, RST_COLLINEAR);
		write_reg(REG_MIN_RADIUS, RST_MIN_RADIUS);
		write_reg(REG_MARGIN, 16'h0aaa);
		write_reg(2'd3, 16'h5555);
		random_phase(240, 2000);
		go_idle();

		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hard limit
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
